// ----- hw/rtl/scmp_pkg.sv -----
package scmp_pkg;

  // sizes and modulus
  localparam int MAX_SIZE  = 100;
  localparam int SIZE_W    = 7;
  localparam int CNT_W     = 30;
  localparam int IDX_W     = $clog2(MAX_SIZE + 1);
  localparam int DEPTH     = MAX_SIZE + 1;
  localparam int MUL_STEPS = CNT_W;
  localparam int STEP_W    = $clog2(MUL_STEPS);
  localparam int BIT_W     = $clog2(SIZE_W);
  localparam logic [CNT_W-1:0] PRIME = CNT_W'(1000000007);

  typedef logic [CNT_W-1:0]  cnt_t;
  typedef logic [SIZE_W-1:0] size_t;
  typedef logic [IDX_W-1:0]  idx_t;

  // request to and answer from the shared modular multiplier
  typedef struct packed {
    logic start;
    cnt_t a;
    cnt_t b;
  } mul_req_t;

  typedef struct packed {
    logic done;
    logic busy;
    cnt_t p;
  } mul_rsp_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_ROW0,
    ST_ROW1,
    ST_NEXTJ,
    ST_RD,
    ST_ADD,
    ST_MUL,
    ST_ROWTOP,
    ST_POWSQ,
    ST_POWML,
    ST_VAL,
    ST_FACT,
    ST_WR,
    ST_DONE
  } seq_state_t;

  // modular add of two residues
  function automatic cnt_t add_mod(input cnt_t x, input cnt_t y);
    logic [CNT_W:0] s;
    s = {1'b0, x} + {1'b0, y};
    if (s >= {1'b0, PRIME}) begin
      s = s - {1'b0, PRIME};
    end
    return s[CNT_W-1:0];
  endfunction

  // modular subtract of two residues
  function automatic cnt_t sub_mod(input cnt_t x, input cnt_t y);
    cnt_t d;
    d = x - y;
    if (x < y) begin
      d = d + PRIME;
    end
    return d;
  endfunction

endpackage

// ----- hw/rtl/scmp_mulmod.sv -----
module scmp_mulmod (
  input  logic              clk,
  input  logic              rst_n,
  input  scmp_pkg::mul_req_t req,
  output scmp_pkg::mul_rsp_t rsp
);
  import scmp_pkg::*;

  cnt_t              a_r, a_nxt;
  cnt_t              b_r, b_nxt;
  cnt_t              acc_r, acc_nxt;
  logic [STEP_W-1:0] step_r, step_nxt;
  logic              busy_r, busy_nxt;
  logic              done_r, done_nxt;

  // one multiplier bit per cycle, msb first, reduced every step
  always_comb begin
    cnt_t dbl;
    a_nxt    = a_r;
    b_nxt    = b_r;
    acc_nxt  = acc_r;
    step_nxt = step_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    dbl      = add_mod(acc_r, acc_r);
    if (req.start) begin
      a_nxt    = req.a;
      b_nxt    = req.b;
      acc_nxt  = '0;
      step_nxt = '0;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      acc_nxt = b_r[CNT_W-1] ? add_mod(dbl, a_r) : dbl;
      b_nxt   = {b_r[CNT_W-2:0], 1'b0};
      if (step_r == STEP_W'(MUL_STEPS - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end else begin
        step_nxt = step_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    a_r    <= a_nxt;
    b_r    <= b_nxt;
    acc_r  <= acc_nxt;
    step_r <= step_nxt;
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
  end

  assign rsp.done = done_r;
  assign rsp.busy = busy_r;
  assign rsp.p    = acc_r;

  // checks
  a_no_restart: assert property (@(posedge clk) disable iff (!rst_n)
    !(req.start && busy_r)) else $error("multiplier restarted while busy");
  a_done_range: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |-> (acc_r < PRIME)) else $error("product not reduced");
  a_done_end: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |-> !busy_r) else $error("done while still busy");

endmodule

// ----- hw/rtl/scmp_seq.sv -----
module scmp_seq (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               req_valid,
  output logic               req_ready,
  input  scmp_pkg::size_t    req_domain,
  input  scmp_pkg::size_t    req_codomain,
  output logic               res_valid,
  input  logic               res_ready,
  output scmp_pkg::cnt_t     res_count,
  output scmp_pkg::mul_req_t mreq,
  input  scmp_pkg::mul_rsp_t mrsp
);
  import scmp_pkg::*;

  seq_state_t        state_r, state_nxt;
  size_t             n_r, n_nxt;
  size_t             m_r, m_nxt;
  idx_t              j_r, j_nxt;
  idx_t              i_r, i_nxt;
  logic [SIZE_W:0]   k_r, k_nxt;
  logic [BIT_W-1:0]  bit_r, bit_nxt;
  cnt_t              prev_r, prev_nxt;
  cnt_t              sum_r, sum_nxt;
  cnt_t              acc_r, acc_nxt;
  cnt_t              binom_r, binom_nxt;
  cnt_t              pcv_r, pcv_nxt;
  cnt_t              wval_r, wval_nxt;
  cnt_t              res_r, res_nxt;
  logic              direct_r, direct_nxt;
  logic              issued_r, issued_nxt;

  // pascal row rebuilt in place, and the partial counts
  cnt_t row_mem [DEPTH];
  cnt_t pc_mem  [DEPTH];
  cnt_t row_q, pc_q;
  logic row_we, pc_we;
  idx_t row_waddr, row_raddr, pc_waddr, pc_raddr;
  cnt_t row_wdata, pc_wdata;

  always_ff @(posedge clk) begin
    if (row_we) begin
      row_mem[row_waddr] <= row_wdata;
    end
    row_q <= row_mem[row_raddr];
  end

  always_ff @(posedge clk) begin
    if (pc_we) begin
      pc_mem[pc_waddr] <= pc_wdata;
    end
    pc_q <= pc_mem[pc_raddr];
  end

  // sequencer
  always_comb begin
    cnt_t binom;
    logic j_is_n;
    state_nxt  = state_r;
    n_nxt      = n_r;
    m_nxt      = m_r;
    j_nxt      = j_r;
    i_nxt      = i_r;
    k_nxt      = k_r;
    bit_nxt    = bit_r;
    prev_nxt   = prev_r;
    sum_nxt    = sum_r;
    acc_nxt    = acc_r;
    binom_nxt  = binom_r;
    pcv_nxt    = pcv_r;
    wval_nxt   = wval_r;
    res_nxt    = res_r;
    direct_nxt = direct_r;
    issued_nxt = issued_r;
    row_we     = 1'b0;
    row_waddr  = i_r;
    row_wdata  = binom_r;
    row_raddr  = i_r;
    pc_we      = 1'b0;
    pc_waddr   = j_r;
    pc_wdata   = wval_r;
    pc_raddr   = j_r - i_r;
    mreq       = '0;
    req_ready  = 1'b0;
    res_valid  = 1'b0;
    binom      = add_mod(row_q, prev_r);
    j_is_n     = ({1'b0, j_r} == (IDX_W + 1)'(n_r));

    unique case (state_r)
      ST_IDLE: begin
        req_ready = 1'b1;
        if (req_valid) begin
          n_nxt      = req_domain;
          m_nxt      = req_codomain;
          acc_nxt    = CNT_W'(1);
          k_nxt      = (SIZE_W + 1)'(1);
          direct_nxt = 1'b1;
          issued_nxt = 1'b0;
          priority if (req_codomain == '0) begin
            res_nxt   = '0;
            state_nxt = ST_DONE;
          end else if (req_codomain == SIZE_W'(1)) begin
            res_nxt   = CNT_W'(1);
            state_nxt = ST_DONE;
          end else if (req_codomain == req_domain) begin
            state_nxt = ST_FACT;
          end else if (32'(req_codomain) > MAX_SIZE) begin
            res_nxt   = '0;
            state_nxt = ST_DONE;
          end else begin
            direct_nxt = 1'b0;
            state_nxt  = ST_ROW0;
          end
        end
      end

      // row one of the triangle and the count for size one
      ST_ROW0: begin
        row_we    = 1'b1;
        row_waddr = '0;
        row_wdata = CNT_W'(1);
        state_nxt = ST_ROW1;
      end

      ST_ROW1: begin
        row_we    = 1'b1;
        row_waddr = IDX_W'(1);
        row_wdata = CNT_W'(1);
        pc_we     = 1'b1;
        pc_waddr  = IDX_W'(1);
        pc_wdata  = CNT_W'(1);
        j_nxt     = IDX_W'(2);
        state_nxt = ST_NEXTJ;
      end

      ST_NEXTJ: begin
        i_nxt     = IDX_W'(1);
        prev_nxt  = CNT_W'(1);
        sum_nxt   = '0;
        state_nxt = ST_RD;
      end

      ST_RD: begin
        state_nxt = ST_ADD;
      end

      // new binomial from the old row, then the product term unless j is the domain size
      ST_ADD: begin
        row_we    = 1'b1;
        row_wdata = binom;
        prev_nxt  = row_q;
        binom_nxt = binom;
        pcv_nxt   = pc_q;
        if (j_is_n) begin
          if (i_r == j_r - 1'b1) begin
            state_nxt = ST_ROWTOP;
          end else begin
            i_nxt     = i_r + 1'b1;
            state_nxt = ST_RD;
          end
        end else begin
          state_nxt = ST_MUL;
        end
      end

      ST_MUL: begin
        if (!issued_r) begin
          mreq.start = 1'b1;
          mreq.a     = binom_r;
          mreq.b     = pcv_r;
          issued_nxt = 1'b1;
        end else if (mrsp.done) begin
          issued_nxt = 1'b0;
          sum_nxt    = add_mod(sum_r, mrsp.p);
          if (i_r == j_r - 1'b1) begin
            state_nxt = ST_ROWTOP;
          end else begin
            i_nxt     = i_r + 1'b1;
            state_nxt = ST_RD;
          end
        end
      end

      ST_ROWTOP: begin
        row_we    = 1'b1;
        row_waddr = j_r;
        row_wdata = CNT_W'(1);
        acc_nxt   = CNT_W'(1);
        k_nxt     = (SIZE_W + 1)'(1);
        bit_nxt   = BIT_W'(SIZE_W - 1);
        state_nxt = j_is_n ? ST_FACT : ST_POWSQ;
      end

      // power by square and multiply, msb first
      ST_POWSQ: begin
        if (!issued_r) begin
          mreq.start = 1'b1;
          mreq.a     = acc_r;
          mreq.b     = acc_r;
          issued_nxt = 1'b1;
        end else if (mrsp.done) begin
          issued_nxt = 1'b0;
          acc_nxt    = mrsp.p;
          if (n_r[bit_r]) begin
            state_nxt = ST_POWML;
          end else if (bit_r == '0) begin
            state_nxt = ST_VAL;
          end else begin
            bit_nxt   = bit_r - 1'b1;
            state_nxt = ST_POWSQ;
          end
        end
      end

      ST_POWML: begin
        if (!issued_r) begin
          mreq.start = 1'b1;
          mreq.a     = acc_r;
          mreq.b     = CNT_W'(j_r);
          issued_nxt = 1'b1;
        end else if (mrsp.done) begin
          issued_nxt = 1'b0;
          acc_nxt    = mrsp.p;
          if (bit_r == '0) begin
            state_nxt = ST_VAL;
          end else begin
            bit_nxt   = bit_r - 1'b1;
            state_nxt = ST_POWSQ;
          end
        end
      end

      ST_VAL: begin
        wval_nxt  = sub_mod(acc_r, sum_r);
        state_nxt = ST_WR;
      end

      // factorial of the domain size
      ST_FACT: begin
        if (!issued_r) begin
          if (k_r > {1'b0, n_r}) begin
            if (direct_r) begin
              res_nxt   = acc_r;
              state_nxt = ST_DONE;
            end else begin
              wval_nxt  = acc_r;
              state_nxt = ST_WR;
            end
          end else begin
            mreq.start = 1'b1;
            mreq.a     = acc_r;
            mreq.b     = CNT_W'(k_r);
            issued_nxt = 1'b1;
          end
        end else if (mrsp.done) begin
          issued_nxt = 1'b0;
          acc_nxt    = mrsp.p;
          k_nxt      = k_r + 1'b1;
        end
      end

      ST_WR: begin
        pc_we = 1'b1;
        if ({1'b0, j_r} == (IDX_W + 1)'(m_r)) begin
          res_nxt   = wval_r;
          state_nxt = ST_DONE;
        end else begin
          j_nxt     = j_r + 1'b1;
          state_nxt = ST_NEXTJ;
        end
      end

      ST_DONE: begin
        res_valid = 1'b1;
        if (res_ready) begin
          state_nxt = ST_IDLE;
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_IDLE;
      issued_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      issued_r <= issued_nxt;
    end
  end

  always_ff @(posedge clk) begin
    n_r      <= n_nxt;
    m_r      <= m_nxt;
    j_r      <= j_nxt;
    i_r      <= i_nxt;
    k_r      <= k_nxt;
    bit_r    <= bit_nxt;
    prev_r   <= prev_nxt;
    sum_r    <= sum_nxt;
    acc_r    <= acc_nxt;
    binom_r  <= binom_nxt;
    pcv_r    <= pcv_nxt;
    wval_r   <= wval_nxt;
    res_r    <= res_nxt;
    direct_r <= direct_nxt;
  end

  assign res_count = res_r;

  // checks
  a_res_range: assert property (@(posedge clk) disable iff (!rst_n)
    res_valid |-> (res_r < PRIME)) else $error("result not reduced");
  a_term_index: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_RD) |-> (i_r < j_r && i_r != '0)) else $error("term index out of row");
  a_mul_wait: assert property (@(posedge clk) disable iff (!rst_n)
    mrsp.done |-> issued_r) else $error("product arrived with no request out");

endmodule

// ----- hw/rtl/surjection_count_mod_prime_unit.sv -----
// Counts the onto maps from a domain onto a codomain, modulo 1000000007.
// Input channel in_*: one request per query, in_tdata holds domain_size and
// codomain_size. Output channel out_*: one result per request, the count.
// in_tready is high only while the sequencer is idle; one request is worked
// at a time. Trivial codomain sizes (0, 1, or above 100 and other than the
// domain size) are answered directly. Equal sizes compute the factorial.
// Otherwise, for each size j from 2 up to the codomain size, j-1 binomial
// terms plus a power of 7 to 14 products, or the factorial when j is the
// domain size.
// Every product goes through the one bit-serial modular multiplier, which
// sets the throughput.
// The binomials are rebuilt row by row inside each query, so reset needs
// no table fill: synchronous active-low reset clears the control state and
// the block is ready as soon as reset is released.
// A finished result sits in the output register; while the receiver stalls,
// the sequencer still takes the next request and holds its own answer
// until the output register frees.
module surjection_count_mod_prime_unit (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [15:0] in_tdata,   // [6:0] domain_size, [13:7] codomain_size
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata   // [29:0] count
);
  import scmp_pkg::*;

  mul_req_t mreq;
  mul_rsp_t mrsp;
  logic     res_valid, res_ready;
  cnt_t     res_count;
  logic     out_tvalid_r;
  cnt_t     out_count_r;

  scmp_seq u_seq (
    .clk          (clk),
    .rst_n        (rst_n),
    .req_valid    (in_tvalid),
    .req_ready    (in_tready),
    .req_domain   (in_tdata[SIZE_W-1:0]),
    .req_codomain (in_tdata[2*SIZE_W-1:SIZE_W]),
    .res_valid    (res_valid),
    .res_ready    (res_ready),
    .res_count    (res_count),
    .mreq         (mreq),
    .mrsp         (mrsp)
  );

  scmp_mulmod u_mulmod (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (mreq),
    .rsp   (mrsp)
  );

  // output register
  assign res_ready = !out_tvalid_r || out_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_tvalid_r <= 1'b0;
    end else if (res_ready) begin
      out_tvalid_r <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res_ready && res_valid) begin
      out_count_r <= res_count;
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = {2'b00, out_count_r};

endmodule

// ----- bench/onto_count_checker.sv -----
module onto_count_checker (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  input  logic        in_tready,
  input  logic [15:0] in_tdata,
  input  logic        out_tvalid,
  input  logic        out_tready,
  input  logic [31:0] out_tdata,
  output int          errors,
  output int          pending
);
  import scmp_pkg::*;

  localparam longint unsigned MODULUS = 64'd1000000007;

  longint unsigned binom[0:MAX_SIZE][0:MAX_SIZE];
  cnt_t            count_q[$];
  int              result_no;

  // binomials mod prime, zero above the diagonal
  initial begin
    for (int r = 0; r <= MAX_SIZE; r++) begin
      for (int c = 0; c <= MAX_SIZE; c++) begin
        binom[r][c] = 0;
      end
      binom[r][0] = 1;
      binom[r][r] = 1;
      for (int c = 1; c < r; c++) begin
        binom[r][c] = (binom[r-1][c-1] + binom[r-1][c]) % MODULUS;
      end
    end
  end

  function automatic longint unsigned mul_p(input longint unsigned a,
                                            input longint unsigned b);
    return ((a % MODULUS) * (b % MODULUS)) % MODULUS;
  endfunction

  function automatic longint unsigned pow_p(input longint unsigned base,
                                            input int unsigned e);
    longint unsigned r;
    r = 1;
    while (e != 0) begin
      if (e[0]) begin
        r = mul_p(r, base);
      end
      base = mul_p(base, base);
      e = e >> 1;
    end
    return r;
  endfunction

  function automatic longint unsigned fact_p(input int unsigned n);
    longint unsigned r;
    r = 1;
    for (int unsigned k = 1; k <= n; k++) begin
      r = mul_p(r, k);
    end
    return r;
  endfunction

  // onto maps from n elements onto m elements, built up in ascending size
  function automatic cnt_t onto_count(input size_t n, input size_t m);
    longint unsigned part[0:MAX_SIZE];
    longint unsigned acc;
    if (m == 0) begin
      return '0;
    end
    if (m == 1) begin
      return cnt_t'(1);
    end
    if (m == n) begin
      return cnt_t'(fact_p(n));
    end
    if (m > MAX_SIZE) begin
      return '0;
    end
    for (int j = 1; j <= m; j++) begin
      if (j == 1) begin
        part[j] = 1;
      end else if (j == n) begin
        part[j] = fact_p(n);
      end else begin
        acc = 0;
        for (int i = 1; i < j; i++) begin
          acc = (acc + mul_p(binom[j][i], part[j-i])) % MODULUS;
        end
        part[j] = (pow_p(j, n) + MODULUS - acc) % MODULUS;
      end
    end
    return cnt_t'(part[m]);
  endfunction

  task automatic report(input string what, input cnt_t got, input cnt_t want);
    $display("mismatch at result %0d: %s got %0d expected %0d", result_no, what, got,
             want);
    errors++;
  endtask

  assign pending = count_q.size();

  // predict on each request, compare on each result
  always @(posedge clk) begin
    if (!rst_n) begin
      count_q.delete();
      errors <= errors;
    end else begin
      if (in_tvalid && in_tready) begin
        count_q.push_back(onto_count(in_tdata[6:0], in_tdata[13:7]));
      end
      if (out_tvalid && out_tready) begin
        if (count_q.size() == 0) begin
          report("unexpected count", out_tdata[29:0], '0);
        end else if (out_tdata[29:0] !== count_q[0]) begin
          report("count", out_tdata[29:0], count_q[0]);
          void'(count_q.pop_front());
        end else begin
          void'(count_q.pop_front());
        end
        result_no++;
      end
    end
  end

  initial begin
    errors = 0;
    result_no = 0;
  end
endmodule

// ----- bench/surjection_count_mod_prime_unit_tb.sv -----
module surjection_count_mod_prime_unit_tb;
  import scmp_pkg::*;

  localparam int CYCLE_LIMIT = 20000000;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [15:0] in_tdata;
  logic        out_tvalid;
  logic        out_tready;
  logic [31:0] out_tdata;
  int          errors;
  int          pending;
  int          cycles;
  int          send_idle_pct;
  int          recv_idle_pct;
  bit          hold_off;

  surjection_count_mod_prime_unit dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata)
  );

  onto_count_checker chk (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .errors(errors), .pending(pending)
  );

  initial clk = 1'b0;
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // watchdog
  initial cycles = 0;
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  // receiver: random stalls, plus one long hold-off on request
  initial begin
    out_tready = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_off) begin
        out_tready <= 1'b0;
        repeat (400) @(posedge clk);
        hold_off = 1'b0;
      end
      out_tready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // one request, with random gaps ahead of it
  task automatic send_query(input size_t n, input size_t m);
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {2'b00, m, n};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
  endtask

  initial begin
    size_t n;
    size_t m;
    int    pick;
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    hold_off = 1'b0;
    send_idle_pct = 8;
    recv_idle_pct = 8;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    // directed: extremes and special sizes
    send_query(0, 0);     send_query(0, 1);     send_query(0, 5);
    send_query(1, 0);     send_query(1, 1);     send_query(5, 5);
    send_query(100, 100); send_query(127, 127); send_query(127, 0);
    send_query(3, 2);     send_query(2, 3);     send_query(127, 101);
    send_query(0, 127);   send_query(99, 100);  send_query(7, 4);
    send_query(64, 64);   send_query(10, 3);    send_query(127, 9);
    send_query(42, 21);

    // long receiver hold-off while quick requests keep coming
    hold_off = 1'b1;
    for (int k = 0; k < 10; k++) begin
      send_query(size_t'($urandom_range(127)), size_t'($urandom_range(1)));
    end

    // random: mostly small codomains, some medium, out-of-range and equal-size ones
    for (int k = 0; k < 70; k++) begin
      if (k == 30) begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end else if (k == 60) begin
        send_idle_pct = 8;
        recv_idle_pct = 8;
      end
      n = size_t'($urandom_range(127));
      pick = $urandom_range(99);
      if (pick < 80) begin
        m = size_t'($urandom_range(12));
      end else if (pick < 86) begin
        m = size_t'($urandom_range(30, 13));
      end else if (pick < 93) begin
        m = size_t'($urandom_range(127, 101));
      end else begin
        m = n;
      end
      send_query(n, m);
    end
    in_tvalid <= 1'b0;

    // drain, then a short quiet period
    while (pending != 0) @(posedge clk);
    repeat (200) @(posedge clk);
    if (errors == 0 && pending == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end
endmodule
